// File: hdl/dle_pkg.sv
// Shared codes, constants and control structs of the decimal line entry editor.
package dle_pkg;

    localparam int LINE_DEPTH_DEF = 64;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [1:0] ST_DISABLED = 2'd0;
    localparam logic [1:0] ST_COLLECT  = 2'd1;
    localparam logic [1:0] ST_READY    = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_BYTE  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;

    localparam logic [1:0] NOTE_NONE     = 2'd0;
    localparam logic [1:0] NOTE_TOO_LONG = 2'd1;
    localparam logic [1:0] NOTE_NOT_DIG  = 2'd2;
    localparam logic [1:0] NOTE_NO_VALID = 2'd3;

    localparam logic       TYPE_DECIMAL = 1'b0;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_DEL  = 8'h7F;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // take the input word
        logic walk_start;  // clear walk counters
        logic walk_step;   // one step of the digit walk
        logic walk_finish; // close the walk and set status
        logic load_out;    // move the result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_req;    // input word is a CR that needs the digit walk
        logic walk_done;
    } t_sts;

endpackage

// File: hdl/dle_ctrl.sv
// Sequencer of the line editor: input/output handshake and digit walk control.
module dle_ctrl
    import dle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.walk_req) begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = S_WALK;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    o_cmd.walk_finish = 1'b1;
                    n_state           = S_PUSH;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/dle_dp.sv
// Line editor datapath: line store, fill count, status, digit walk, output word.
module dle_dp
    import dle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_entry_type,
    output logic [1:0]  o_line_status,
    output logic [1:0]  o_echo_kind,
    output logic [7:0]  o_echo_char,
    output logic [1:0]  o_note,
    output logic [30:0] o_value
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0] FILL_LAST = AW'(LINE_DEPTH - 1);

    logic [7:0]    r_mem [LINE_DEPTH];
    logic [7:0]    r_rd_data;

    logic [1:0]    r_status, n_status;
    logic          r_type, n_type;
    logic [AW-1:0] r_fill, n_fill;
    logic [1:0]    r_echo_kind, n_echo_kind;
    logic [7:0]    r_echo_char, n_echo_char;
    logic [1:0]    r_note, n_note;
    logic [30:0]   r_value, n_value;

    logic [AW-1:0] r_idx, n_idx;
    logic          r_rd_vld, n_rd_vld;
    logic [30:0]   r_acc, n_acc;
    logic          r_bad, n_bad;

    logic          is_full;
    logic          is_digit;
    logic [7:0]    digit_off;
    logic [34:0]   acc_next;
    logic          mem_we;

    logic [1:0]    r_out_status;
    logic [1:0]    r_out_echo_kind;
    logic [7:0]    r_out_echo_char;
    logic [1:0]    r_out_note;
    logic [30:0]   r_out_value;

    assign is_full   = (r_fill == FILL_LAST);
    assign is_digit  = r_rd_data inside {[CHAR_ZERO:CHAR_NINE]};
    assign digit_off = r_rd_data - CHAR_ZERO;
    // acc * 10 + digit
    assign acc_next  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                     + {31'd0, digit_off[3:0]};

    assign o_sts.walk_req  = (i_op == OP_BYTE) && (r_status == ST_COLLECT) && !is_full
                           && (i_rx_byte == CHAR_CR) && (r_type == TYPE_DECIMAL);
    assign o_sts.walk_done = (r_idx == r_fill) && !r_rd_vld;

    always_comb begin
        n_status    = r_status;
        n_type      = r_type;
        n_fill      = r_fill;
        n_echo_kind = r_echo_kind;
        n_echo_char = r_echo_char;
        n_note      = r_note;
        n_value     = r_value;
        n_idx       = r_idx;
        n_rd_vld    = r_rd_vld;
        n_acc       = r_acc;
        n_bad       = r_bad;
        mem_we      = 1'b0;

        if (i_cmd.accept) begin
            n_echo_kind = ECHO_NONE;
            n_echo_char = 8'd0;
            n_note      = NOTE_NONE;
            case (i_op)
                OP_BEGIN: begin
                    n_status = ST_COLLECT;
                    n_type   = i_entry_type;
                    n_fill   = '0;
                end
                OP_END: begin
                    n_status = ST_DISABLED;
                end
                OP_BYTE: begin
                    if (r_status == ST_COLLECT) begin
                        if (is_full) begin
                            n_status = ST_INVALID;
                            n_note   = NOTE_TOO_LONG;
                        end else if (i_rx_byte == CHAR_CR) begin
                            // decimal type goes through the walk instead
                            if (r_type != TYPE_DECIMAL) begin
                                n_status = ST_INVALID;
                                n_note   = NOTE_NO_VALID;
                            end
                        end else if (i_rx_byte == CHAR_DEL) begin
                            if (r_fill != '0) begin
                                n_fill      = r_fill - 1'b1;
                                n_echo_kind = ECHO_ERASE;
                            end
                        end else begin
                            mem_we      = 1'b1;
                            n_fill      = r_fill + 1'b1;
                            n_echo_kind = ECHO_BYTE;
                            n_echo_char = i_rx_byte;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.walk_start) begin
            n_idx    = '0;
            n_rd_vld = 1'b0;
            n_acc    = '0;
            n_bad    = 1'b0;
        end

        if (i_cmd.walk_step) begin
            if (r_idx != r_fill) begin
                n_idx    = r_idx + 1'b1;
                n_rd_vld = 1'b1;
            end else begin
                n_rd_vld = 1'b0;
            end
            if (r_rd_vld) begin
                if (!is_digit) begin
                    n_bad = 1'b1;
                end else if (acc_next > {4'd0, VALUE_MAX}) begin
                    n_acc = VALUE_MAX;
                end else begin
                    n_acc = acc_next[30:0];
                end
            end
        end

        if (i_cmd.walk_finish) begin
            n_status = r_bad ? ST_INVALID : ST_READY;
            n_note   = r_bad ? NOTE_NOT_DIG : NOTE_NONE;
            n_value  = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill] <= i_rx_byte;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_DISABLED;
            r_type   <= TYPE_DECIMAL;
            r_fill   <= '0;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_status <= n_status;
            r_type   <= n_type;
            r_fill   <= n_fill;
            r_rd_vld <= n_rd_vld;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_echo_kind <= n_echo_kind;
        r_echo_char <= n_echo_char;
        r_note      <= n_note;
        r_value     <= n_value;
        r_acc       <= n_acc;
        r_bad       <= n_bad;
        if (i_cmd.load_out) begin
            r_out_status    <= r_status;
            r_out_echo_kind <= r_echo_kind;
            r_out_echo_char <= r_echo_char;
            r_out_note      <= r_note;
            r_out_value     <= (r_status == ST_READY && r_type == TYPE_DECIMAL)
                               ? r_value : 31'd0;
        end
    end

    assign o_line_status = r_out_status;
    assign o_echo_kind   = r_out_echo_kind;
    assign o_echo_char   = r_out_echo_char;
    assign o_note        = r_out_note;
    assign o_value       = r_out_value;

endmodule

// File: hdl/decimal_line_entry_editor.sv
// Top level of the decimal line entry editor.
// Each input word (received byte, begin or end) gives exactly one output word with the
// line status, the echo to send back, a note code and, while a decimal line is ready,
// its value saturated at 2147483647. A CR on a decimal line walks the stored bytes
// through the single read port of the line store, one byte a cycle. The input is
// stalled while a word is in work; a finished word may wait in the output register
// while the next input word is taken. The line store has no reset.
module decimal_line_entry_editor
    import dle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_entry_type,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_line_status,
    output logic [1:0]  o_echo_kind,
    output logic [7:0]  o_echo_char,
    output logic [1:0]  o_note,
    output logic [30:0] o_value
);

    t_cmd cmd;
    t_sts sts;

    dle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dle_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_rx_byte     (i_rx_byte),
        .i_entry_type  (i_entry_type),
        .o_line_status (o_line_status),
        .o_echo_kind   (o_echo_kind),
        .o_echo_char   (o_echo_char),
        .o_note        (o_note),
        .o_value       (o_value)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the decimal line entry editor.
`timescale 1ns / 100ps

module tb;
    import dle_pkg::*;

    localparam int DEPTH       = LINE_DEPTH_DEF;
    localparam int WORD_TARGET = 1700;
    localparam int CALM_FROM   = 1500;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 80;

    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  echo_kind;
        logic [7:0]  echo_char;
        logic [1:0]  note;
        logic [30:0] value;
    } t_line_word;

    // Mirror of the editor: line store, status and the replies still owed.
    class line_editor_board;
        logic [1:0]  status;
        logic        etype;
        int unsigned fill;
        logic [7:0]  store [DEPTH];
        t_line_word  due [$];
        int          errors;
        int          replies;
        int          ready_lines;
        int          saturated;
        int          notes [4];

        function new();
            status = ST_DISABLED;
            etype  = TYPE_DECIMAL;
            fill   = 0;
        endfunction

        // Decimal value of the stored line, saturating; ok drops on a non-digit.
        function logic [30:0] scan_line(output bit ok);
            longint unsigned acc;
            acc = 0;
            ok  = 1'b1;
            for (int i = 0; i < fill; i++) begin
                if (store[i] < CHAR_ZERO || store[i] > CHAR_NINE) begin
                    ok = 1'b0;
                    return '0;
                end
                acc = acc * 10 + (store[i] - CHAR_ZERO);
                if (acc > VALUE_MAX)
                    acc = VALUE_MAX;
            end
            return acc[30:0];
        endfunction

        // Returns 1 when the word changes or can change the editor.
        function bit log_input(logic [1:0] op, logic [7:0] rx, logic et);
            t_line_word w;
            bit         handled;
            bit         ok;
            bit         closed;
            w       = '0;
            handled = 1'b1;
            closed  = 1'b0;
            case (op)
                OP_BEGIN: begin
                    status = ST_COLLECT;
                    etype  = et;
                    fill   = 0;
                end
                OP_END: status = ST_DISABLED;
                OP_BYTE: begin
                    if (status != ST_COLLECT) begin
                        handled = 1'b0;
                    end else if (fill >= DEPTH - 1) begin
                        status = ST_INVALID;
                        w.note = NOTE_TOO_LONG;
                    end else if (rx == CHAR_CR) begin
                        closed = 1'b1;
                        if (etype != TYPE_DECIMAL) begin
                            status = ST_INVALID;
                            w.note = NOTE_NO_VALID;
                        end else begin
                            void'(scan_line(ok));
                            if (ok) begin
                                status = ST_READY;
                            end else begin
                                status = ST_INVALID;
                                w.note = NOTE_NOT_DIG;
                            end
                        end
                    end else if (rx == CHAR_DEL) begin
                        if (fill > 0) begin
                            fill--;
                            w.echo_kind = ECHO_ERASE;
                        end
                    end else begin
                        store[fill] = rx;
                        fill++;
                        w.echo_kind = ECHO_BYTE;
                        w.echo_char = rx;
                    end
                end
                default: handled = 1'b0;
            endcase
            if (status == ST_READY && etype == TYPE_DECIMAL)
                w.value = scan_line(ok);
            w.status = status;
            due.push_back(w);
            if (w.note != NOTE_NONE)
                notes[w.note]++;
            if (closed && status == ST_READY) begin
                ready_lines++;
                if (w.value == VALUE_MAX)
                    saturated++;
            end
            return handled;
        endfunction

        function void cmp_field(string name, logic [30:0] want, logic [30:0] seen);
            if (seen !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, seen);
            end
        endfunction

        function void check_reply(t_line_word got);
            t_line_word want;
            replies++;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: unexpected output word, expected none, actual %h", $time, got);
                return;
            end
            want = due.pop_front();
            cmp_field("line_status", 31'(want.status), 31'(got.status));
            cmp_field("echo_kind", 31'(want.echo_kind), 31'(got.echo_kind));
            cmp_field("echo_char", 31'(want.echo_char), 31'(got.echo_char));
            cmp_field("note", 31'(want.note), 31'(got.note));
            cmp_field("value", want.value, got.value);
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_op         = OP_BYTE;
    logic [7:0]  i_rx_byte    = 8'h00;
    logic        i_entry_type = TYPE_DECIMAL;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_line_status;
    logic [1:0]  o_echo_kind;
    logic [7:0]  o_echo_char;
    logic [1:0]  o_note;
    logic [30:0] o_value;

    line_editor_board board = new;
    bit               calm;
    int               words_taken;
    int               words_sent;
    int               stall_left;
    int               quiet_cycles;

    decimal_line_entry_editor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_rx_byte     (i_rx_byte),
        .i_entry_type  (i_entry_type),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_line_status (o_line_status),
        .o_echo_kind   (o_echo_kind),
        .o_echo_char   (o_echo_char),
        .o_note        (o_note),
        .o_value       (o_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: check accepted words, then pick the next stall state.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_reply({o_line_status, o_echo_kind, o_echo_char, o_note, o_value});
        if (stall_left > 0) begin
            stall_left--;
        end else if (!calm && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    task automatic put_word(input logic [1:0] op, input logic [7:0] rx, input logic et);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_rx_byte    <= rx;
        i_entry_type <= et;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        words_sent++;
        if (board.log_input(op, rx, et))
            words_taken++;
        if (words_sent >= CALM_FROM)
            calm = 1'b1;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_word(OP_BYTE, s[i], 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_CR || b == CHAR_DEL);
        return b;
    endfunction

    function automatic logic [7:0] any_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Mostly well-formed lines: begin, content, CR, then trailing noise or end.
    task automatic random_line();
        int pick;
        int len;
        int p;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 6))
                put_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            return;
        end
        put_word(OP_BEGIN, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            // fill the line to its limit of DEPTH - 1 bytes, then overflow it
            repeat (DEPTH - 1)
                put_word(OP_BYTE, ($urandom_range(0, 3) == 0) ? plain_byte() : any_digit(),
                         1'b0);
            put_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            len = (pick < 20) ? $urandom_range(9, 20) : $urandom_range(0, 8);
            repeat (len) begin
                p = $urandom_range(0, 99);
                if (p < 75)
                    put_word(OP_BYTE, any_digit(), 1'($urandom_range(0, 1)));
                else if (p < 86)
                    put_word(OP_BYTE, CHAR_DEL, 1'($urandom_range(0, 1)));
                else if (p < 97)
                    put_word(OP_BYTE, plain_byte(), 1'($urandom_range(0, 1)));
                else
                    put_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        put_word(OP_BYTE, CHAR_CR, 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            repeat ($urandom_range(1, 3))
                put_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else if (pick < 6)
            put_word(OP_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled editor and the spare op code: both ignored
        put_word(OP_BYTE, 8'hFF, 1'b1);
        put_word(OP_SPARE, 8'hA5, 1'b1);
        // entry type with no validator
        put_word(OP_BEGIN, 8'h00, 1'b1);
        put_word(OP_BYTE, 8'h41, 1'b0);
        put_word(OP_BYTE, CHAR_CR, 1'b0);
        // DEL on an empty line, erase, zero byte, then a byte after invalid
        put_word(OP_BEGIN, 8'h00, TYPE_DECIMAL);
        put_word(OP_BYTE, CHAR_DEL, 1'b0);
        put_word(OP_BYTE, CHAR_ZERO + 8'd5, 1'b0);
        put_word(OP_BYTE, CHAR_DEL, 1'b0);
        put_word(OP_BYTE, 8'h00, 1'b0);
        put_word(OP_BYTE, CHAR_CR, 1'b0);
        put_word(OP_BYTE, CHAR_ZERO + 8'd5, 1'b0);
        // value above the saturation limit
        put_word(OP_BEGIN, 8'hFF, TYPE_DECIMAL);
        put_text("9876543210");
        put_word(OP_BYTE, CHAR_CR, 1'b1);
        put_word(OP_END, 8'h00, 1'b0);

        while (words_sent < WORD_TARGET)
            random_line();

        i_in_valid <= 1'b0;
        while (board.due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d input words (%0d handled), %0d output words checked",
                 words_sent, words_taken, board.replies);
        $display("run: %0d ready lines (%0d saturated), too long %0d, non-digit %0d,",
                 board.ready_lines, board.saturated, board.notes[NOTE_TOO_LONG],
                 board.notes[NOTE_NOT_DIG]);
        $display("run: no validator %0d", board.notes[NOTE_NO_VALID]);
        if (board.errors == 0 && board.due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: sim.f
hdl/dle_pkg.sv
hdl/dle_ctrl.sv
hdl/dle_dp.sv
hdl/decimal_line_entry_editor.sv
sim/tb.sv
